// ----- src/brfds_pkg.sv -----
// ============================================================================
// brfds_pkg
// Shared types and constants for the byte ring FIFO with drop statistics.
// ============================================================================
package brfds_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int MAX_DRAIN  = 64;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int LEN_W  = 7;
    localparam int FILL_W = 11;
    localparam int STAT_W = 32;
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROP    = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [7:0]       push_byte;
        logic [LEN_W-1:0] drain_limit;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              data_valid;
        logic [7:0]        out_byte;
        logic              last;
        logic [LEN_W-1:0]  drained_len;
        logic [FILL_W-1:0] pending_count;
        logic [STAT_W-1:0] total_appended;
        logic [STAT_W-1:0] dropped_total;
        logic [FILL_W-1:0] peak_fill;
        logic [STAT_W-1:0] drained_total;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_DRAIN,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       push_byte;
        logic [LEN_W-1:0] limit;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT
    } back_state_t;

endpackage

// ----- src/brfds_front.sv -----
// ============================================================================
// brfds_front
// Accept requests, classify them and hold them in a two-entry command queue.
// ============================================================================
module brfds_front
    import brfds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       push;

    // Classify: zero length is an error, saturate long drains.
    always_comb begin
        cls.push_byte = s_data.push_byte;
        cls.limit     = s_data.drain_limit;
        if (s_data.operation == OP_PUSH) begin
            cls.kind = CMD_PUSH;
        end else if (s_data.drain_limit == '0) begin
            cls.kind = CMD_BAD;
        end else begin
            cls.kind = CMD_DRAIN;
            if (s_data.drain_limit > LEN_W'(MAX_DRAIN)) begin
                cls.limit = LEN_W'(MAX_DRAIN);
            end
        end
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_idx_reg];

    always_comb begin
        wr_idx_next = push ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = cmd_pop ? ~rd_idx_reg : rd_idx_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_idx_reg] <= cls;
        end
    end

endmodule

// ----- src/brfds_back.sv -----
// ============================================================================
// brfds_back
// Execute commands: ring memory, pointers, statistics and the result register.
// ============================================================================
module brfds_back
    import brfds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rdata_reg;
    logic       mem_we;

    back_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  hwm_reg, hwm_next;
    logic [STAT_W-1:0] appended_reg, appended_next;
    logic [STAT_W-1:0] dropped_reg, dropped_next;
    logic [STAT_W-1:0] drained_reg, drained_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    out_item_t         out_reg, out_next;

    logic [CMP_W-1:0] run_w, lim_w, fill_w, n_a, n_w;
    logic [LEN_W-1:0] drain_n;
    logic             ring_full;

    assign ring_full = (fill_reg == CNT_W'(RING_DEPTH));
    assign run_w     = CMP_W'(RING_DEPTH) - CMP_W'(rd_ptr_reg);
    assign lim_w     = CMP_W'(cmd.limit);
    assign fill_w    = CMP_W'(fill_reg);
    assign n_a       = (fill_w < lim_w) ? fill_w : lim_w;
    assign n_w       = (n_a > run_w) ? run_w : n_a;
    assign drain_n   = LEN_W'(n_w);

    assign m_valid = (state_reg == BK_OUT);
    assign m_data  = out_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.kind == CMD_DRAIN && drain_n != '0) begin
                        state_next = BK_READ;
                    end else begin
                        state_next = BK_OUT;
                    end
                end
            end
            BK_READ: state_next = BK_OUT;
            BK_OUT: begin
                if (m_ready) begin
                    state_next = (remain_reg != '0) ? BK_READ : BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        fill_next     = fill_reg;
        hwm_next      = hwm_reg;
        appended_next = appended_reg;
        dropped_next  = dropped_reg;
        drained_next  = drained_reg;
        remain_next   = remain_reg;
        len_next      = len_reg;
        out_next      = out_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop                 = 1'b1;
                    remain_next             = '0;
                    out_next.status         = ST_OK;
                    out_next.data_valid     = 1'b0;
                    out_next.out_byte       = 8'd0;
                    out_next.last           = 1'b1;
                    out_next.drained_len    = '0;
                    case (cmd.kind)
                        CMD_PUSH: begin
                            if (ring_full) begin
                                dropped_next    = dropped_reg + STAT_W'(1);
                                out_next.status = ST_DROP;
                            end else begin
                                mem_we        = 1'b1;
                                wr_ptr_next   = (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ?
                                                '0 : wr_ptr_reg + PTR_W'(1);
                                fill_next     = fill_reg + CNT_W'(1);
                                appended_next = appended_reg + STAT_W'(1);
                                if (fill_next > hwm_reg) begin
                                    hwm_next = fill_next;
                                end
                            end
                        end
                        CMD_DRAIN: begin
                            remain_next = drain_n;
                            len_next    = drain_n;
                        end
                        default: out_next.status = ST_BAD_LEN;
                    endcase
                end
            end
            BK_READ: begin
                rd_ptr_next          = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ?
                                       '0 : rd_ptr_reg + PTR_W'(1);
                fill_next            = fill_reg - CNT_W'(1);
                drained_next         = drained_reg + STAT_W'(1);
                remain_next          = remain_reg - LEN_W'(1);
                out_next.status      = ST_OK;
                out_next.data_valid  = 1'b1;
                out_next.out_byte    = rdata_reg;
                out_next.last        = (remain_reg == LEN_W'(1));
                out_next.drained_len = len_reg;
            end
            default: ;
        endcase
        out_next.pending_count  = FILL_W'(fill_next);
        out_next.total_appended = appended_next;
        out_next.dropped_total  = dropped_next;
        out_next.peak_fill      = FILL_W'(hwm_next);
        out_next.drained_total  = drained_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
            hwm_reg      <= '0;
            appended_reg <= '0;
            dropped_reg  <= '0;
            drained_reg  <= '0;
            remain_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fill_reg     <= fill_next;
            hwm_reg      <= hwm_next;
            appended_reg <= appended_next;
            dropped_reg  <= dropped_next;
            drained_reg  <= drained_next;
            remain_reg   <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        out_reg <= out_next;
    end

    // Ring memory: one write port, one registered read port at the tail.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= cmd.push_byte;
        end
        rdata_reg <= mem[rd_ptr_reg];
    end

endmodule

// ----- src/byte_ring_fifo_drop_stats.sv -----
// ============================================================================
// byte_ring_fifo_drop_stats
// Byte ring FIFO with overflow drop, high-water mark and traffic counters.
// ============================================================================
// Flow: with the back engine idle, an accepted request waits in the front queue,
//   is executed in BK_IDLE and registered as the result; a drain instead passes
//   through BK_READ, which fetches a byte, to BK_OUT, which presents it. The back
//   engine executes or fetches and then presents each result, and takes no new
//   command or byte until the result on m_data is taken.
// Reset: synchronous on aresetn low; clears pointers, fill, statistics and
//   the command queue. Ring contents are not cleared and need no sweep.
module byte_ring_fifo_drop_stats
    import brfds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Commands flow from the front queue into the back engine.
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Front: take each request, sort it into push, drain or bad length,
    // saturate the drain length and park it in a short queue so the input
    // side keeps moving while a result waits on m_ready.
    brfds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: own the ring memory and all counters, execute one command at a
    // time, and hold each result in a register until the request is taken.
    // A drain stops at the physical end of the ring; the next drain wraps.
    brfds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- src/brfds_checker.sv -----
// ============================================================================
// brfds_checker
// Port-level assertions for the byte ring FIFO, bound to the top level.
// ============================================================================
module brfds_checker
    import brfds_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Drop no valid result straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A dropped byte means the ring was full.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_DROP |->
            m_data.pending_count == FILL_W'(RING_DEPTH) && !m_data.data_valid)
        else $error("drop reported with ring not full");

    // A drained byte comes with a non-zero length of at most MAX_DRAIN and ok status.
    a_data_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.data_valid |->
            m_data.drained_len != '0 && m_data.status == ST_OK &&
            m_data.drained_len <= LEN_W'(MAX_DRAIN))
        else $error("drained byte with bad length or status");

endmodule

bind byte_ring_fifo_drop_stats brfds_checker u_checker (.*);
